[src/mmc3bm_pkg.sv]
// Package for the MMC3-style bank mapper core: field widths, action and
// register decode codes, controller/datapath command structs and helpers.
// No dependencies.
package mmc3bm_pkg;

   localparam int PRG_BANK_W = 6;
   localparam int CHR_BANK_W = 8;
   localparam int COUNT_W    = 7;
   localparam int ROM_ADDR_W = 19;
   localparam int LINE_W     = 9;

   // One remainder bit is resolved per step, so the step count is the bank width.
   localparam int DIV_STEPS = PRG_BANK_W;

   localparam logic [LINE_W-1:0]  VISIBLE_LINES = 9'd240;
   localparam logic [COUNT_W-1:0] COUNT_RESET   = 7'd32;
   localparam logic [COUNT_W-1:0] COUNT_MIN     = 7'd2;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 7'd64;

   typedef enum logic [1:0] {
      ACT_REG_WRITE = 2'd0,
      ACT_PRG_READ  = 2'd1,
      ACT_CHR_READ  = 2'd2,
      ACT_SCANLINE  = 2'd3
   } action_type;

   // Register decode: {address[15:13], address[0]}.
   typedef enum logic [3:0] {
      REG_SELECT      = 4'b1000,
      REG_BANK_DATA   = 4'b1001,
      REG_MIRROR      = 4'b1010,
      REG_RAM_PROTECT = 4'b1011,
      REG_IRQ_LATCH   = 4'b1100,
      REG_IRQ_RELOAD  = 4'b1101,
      REG_IRQ_DISABLE = 4'b1110,
      REG_IRQ_ENABLE  = 4'b1111
   } reg_code_type;

   typedef struct packed {
      logic load_req;
      logic div_init;
      logic div_step;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic needs_div;
      logic out_free;
   } dp_status_type;

   function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] raw);
      logic [COUNT_W-1:0] n;
      n = raw;
      if (raw < COUNT_MIN) n = COUNT_MIN;
      if (raw > COUNT_MAX) n = COUNT_MAX;
      return n;
   endfunction

   // One restoring step of a remainder by n: shift in the next dividend bit,
   // subtract n once if it fits.
   function automatic logic [PRG_BANK_W-1:0] mod_step(
      input logic [PRG_BANK_W-1:0] rem,
      input logic                  dvd_bit,
      input logic [COUNT_W-1:0]    n
   );
      logic [COUNT_W-1:0] sh;
      logic [COUNT_W-1:0] diff;
      sh   = {rem, dvd_bit};
      diff = sh - n;
      return (sh >= n) ? diff[PRG_BANK_W-1:0] : sh[PRG_BANK_W-1:0];
   endfunction

endpackage

[src/mmc3bm_req_if.sv]
// Request channel interface: valid/ready handshake and one action item.
// Depends on nothing.
interface mmc3bm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [15:0] address;
   logic [7:0] write_data;
   logic [8:0] scanline_number;

   modport source (output valid, output action, output address, output write_data,
                   output scanline_number, input ready);
   modport sink (input valid, input action, input address, input write_data,
                 input scanline_number, output ready);
endinterface

[src/mmc3bm_rsp_if.sv]
// Response channel interface: valid/ready handshake and one result item.
// Depends on nothing.
interface mmc3bm_rsp_if;
   logic        valid;
   logic        ready;
   logic [18:0] rom_address;
   logic        address_valid;
   logic        irq_line;
   logic        mirror_horizontal;

   modport source (output valid, output rom_address, output address_valid,
                   output irq_line, output mirror_horizontal, input ready);
   modport sink (input valid, input rom_address, input address_valid,
                 input irq_line, input mirror_horizontal, output ready);
endinterface

[src/mmc3bm_ctrl.sv]
// Controller state machine for the bank mapper core: sequences request
// capture, the bank remainder steps and the commit. Uses mmc3bm_pkg.
module mmc3bm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mmc3bm_pkg::dp_status_type status,
   output mmc3bm_pkg::ctrl_cmd_type  cmd
);

   localparam int STEP_W = $clog2(mmc3bm_pkg::DIV_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(mmc3bm_pkg::DIV_STEPS - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECODE = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.needs_div) begin
               cmd.div_init = 1'b1;
               step_in      = '0;
               state_in     = ST_DIV;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // Hold here while the previous result still sits in the output register.
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

[src/mmc3bm_dp.sv]
// Datapath for the bank mapper core: mapper registers, bank maps, IRQ
// counter, two bit-serial remainder lanes and the output register.
// Uses mmc3bm_pkg; driven by commands from mmc3bm_ctrl.
module mmc3bm_dp #(
   parameter logic [mmc3bm_pkg::LINE_W-1:0] VISIBLE_LINES = mmc3bm_pkg::VISIBLE_LINES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [6:0]                csr_write_data,
   input  logic [1:0]                req_action,
   input  logic [15:0]               req_address,
   input  logic [7:0]                req_write_data,
   input  logic [8:0]                req_scanline_number,
   input  mmc3bm_pkg::ctrl_cmd_type  cmd,
   output mmc3bm_pkg::dp_status_type status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [18:0]               rsp_rom_address,
   output logic                      rsp_address_valid,
   output logic                      rsp_irq_line,
   output logic                      rsp_mirror_horizontal
);

   localparam int PW = mmc3bm_pkg::PRG_BANK_W;
   localparam int CW = mmc3bm_pkg::CHR_BANK_W;
   localparam int NW = mmc3bm_pkg::COUNT_W;

   // Captured request.
   mmc3bm_pkg::action_type act_ff;
   logic [15:0]            addr_ff;
   logic [7:0]             data_ff;
   logic [8:0]             line_ff;

   // Mapper state.
   logic [NW-1:0] count_ff, count_in;
   logic [2:0]    target_ff, target_in;
   logic          swap_ff, swap_in;
   logic          invert_ff, invert_in;
   logic [CW-1:0] bank_ff [8];
   logic [CW-1:0] bank_in [8];
   logic [CW-1:0] chr_ff [8];
   logic [CW-1:0] chr_in [8];
   logic [PW-1:0] prg_ff [4];
   logic [PW-1:0] prg_in [4];
   logic [7:0]    latch_ff, latch_in;
   logic [7:0]    irqcnt_ff, irqcnt_in;
   logic          reload_ff, reload_in;
   logic          enabled_ff, enabled_in;
   logic          level_ff, level_in;
   logic          mirror_ff, mirror_in;

   // Remainder lanes for R6 and R7.
   logic [PW-1:0] dvd6_ff, dvd6_in, dvd7_ff, dvd7_in;
   logic [PW-1:0] rem6_ff, rem6_in, rem7_ff, rem7_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [18:0]   rom_ff, rom_in;
   logic          aval_ff, aval_in;
   logic          irq_ff;
   logic          mir_ff;

   logic [NW-1:0] count_n;
   logic          prg_target;

   assign count_n    = mmc3bm_pkg::eff_count(count_ff);
   assign prg_target = (target_ff[2:1] == 2'b11);

   assign status.needs_div = (act_ff == mmc3bm_pkg::ACT_REG_WRITE) && prg_target &&
                             (mmc3bm_pkg::reg_code_type'({addr_ff[15:13], addr_ff[0]})
                              == mmc3bm_pkg::REG_BANK_DATA);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Remainder lanes.
   always_comb begin
      dvd6_in = dvd6_ff;
      dvd7_in = dvd7_ff;
      rem6_in = rem6_ff;
      rem7_in = rem7_ff;
      if (cmd.div_init) begin
         // The bank register being written takes its new value here.
         dvd6_in = (target_ff == 3'd6) ? data_ff[PW-1:0] : bank_ff[6][PW-1:0];
         dvd7_in = (target_ff == 3'd7) ? data_ff[PW-1:0] : bank_ff[7][PW-1:0];
         rem6_in = '0;
         rem7_in = '0;
      end else if (cmd.div_step) begin
         rem6_in = mmc3bm_pkg::mod_step(rem6_ff, dvd6_ff[PW-1], count_n);
         rem7_in = mmc3bm_pkg::mod_step(rem7_ff, dvd7_ff[PW-1], count_n);
         dvd6_in = {dvd6_ff[PW-2:0], 1'b0};
         dvd7_in = {dvd7_ff[PW-2:0], 1'b0};
      end
   end

   // Item execution and configuration.
   always_comb begin
      logic [NW-1:0] n2;
      logic [NW-1:0] n1;
      logic [NW-1:0] cfg_n;
      logic [7:0]    cnt_tmp;
      n2 = count_n - 7'd2;
      n1 = count_n - 7'd1;
      cnt_tmp    = irqcnt_ff;
      count_in   = count_ff;
      target_in  = target_ff;
      swap_in    = swap_ff;
      invert_in  = invert_ff;
      bank_in    = bank_ff;
      chr_in     = chr_ff;
      prg_in     = prg_ff;
      latch_in   = latch_ff;
      irqcnt_in  = irqcnt_ff;
      reload_in  = reload_ff;
      enabled_in = enabled_ff;
      level_in   = level_ff;
      mirror_in  = mirror_ff;
      rom_in     = '0;
      aval_in    = 1'b0;

      if (cmd.commit) begin
         unique case (act_ff)
            mmc3bm_pkg::ACT_REG_WRITE: begin
               unique case (mmc3bm_pkg::reg_code_type'({addr_ff[15:13], addr_ff[0]}))
                  mmc3bm_pkg::REG_SELECT: begin
                     target_in = data_ff[2:0];
                     swap_in   = data_ff[6];
                     invert_in = data_ff[7];
                  end
                  mmc3bm_pkg::REG_BANK_DATA: begin
                     if (!prg_target) begin
                        bank_in[target_ff] = data_ff;
                        for (int k = 0; k < 4; k++) begin
                           chr_in[{~invert_ff, 2'(k)}] = bank_in[k + 2];
                        end
                        chr_in[{invert_ff, 2'd0}] = {bank_in[0][CW-1:1], 1'b0};
                        chr_in[{invert_ff, 2'd1}] = {bank_in[0][CW-1:1], 1'b1};
                        chr_in[{invert_ff, 2'd2}] = {bank_in[1][CW-1:1], 1'b0};
                        chr_in[{invert_ff, 2'd3}] = {bank_in[1][CW-1:1], 1'b1};
                     end else begin
                        bank_in[target_ff] = {{(CW-PW){1'b0}}, data_ff[PW-1:0]};
                        if (swap_ff) begin
                           prg_in[2] = rem6_ff;
                           prg_in[0] = n2[PW-1:0];
                        end else begin
                           prg_in[0] = rem6_ff;
                           prg_in[2] = n2[PW-1:0];
                        end
                        prg_in[1] = rem7_ff;
                        prg_in[3] = n1[PW-1:0];
                     end
                  end
                  mmc3bm_pkg::REG_MIRROR:     mirror_in = data_ff[0];
                  mmc3bm_pkg::REG_IRQ_LATCH:  latch_in  = data_ff;
                  mmc3bm_pkg::REG_IRQ_RELOAD: begin
                     reload_in = 1'b1;
                     irqcnt_in = '0;
                  end
                  mmc3bm_pkg::REG_IRQ_DISABLE: begin
                     enabled_in = 1'b0;
                     level_in   = 1'b0;
                  end
                  mmc3bm_pkg::REG_IRQ_ENABLE: enabled_in = 1'b1;
                  // RAM protect and addresses below the register window do nothing.
                  default: ;
               endcase
            end
            mmc3bm_pkg::ACT_PRG_READ: begin
               if (addr_ff[15]) begin
                  rom_in  = {prg_ff[addr_ff[14:13]], addr_ff[12:0]};
                  aval_in = 1'b1;
               end
            end
            mmc3bm_pkg::ACT_CHR_READ: begin
               rom_in  = {1'b0, chr_ff[addr_ff[12:10]], addr_ff[9:0]};
               aval_in = 1'b1;
            end
            mmc3bm_pkg::ACT_SCANLINE: begin
               if (line_ff < VISIBLE_LINES) begin
                  if (reload_ff) begin
                     cnt_tmp   = latch_ff;
                     reload_in = 1'b0;
                  end else if (irqcnt_ff != 8'd0) begin
                     cnt_tmp = irqcnt_ff - 8'd1;
                  end
                  irqcnt_in = cnt_tmp;
                  if (cnt_tmp == 8'd0) begin
                     reload_in = 1'b1;
                     if (enabled_ff) level_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      // A count write reloads the default program bank layout.
      cfg_n = mmc3bm_pkg::eff_count(csr_write_data);
      if (csr_write_enable) begin
         count_in  = csr_write_data;
         prg_in[0] = '0;
         prg_in[1] = PW'(1);
         prg_in[2] = PW'(cfg_n - 7'd2);
         prg_in[3] = PW'(cfg_n - 7'd1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff  <= mmc3bm_pkg::action_type'(req_action);
         addr_ff <= req_address;
         data_ff <= req_write_data;
         line_ff <= req_scanline_number;
      end
      dvd6_ff <= dvd6_in;
      dvd7_ff <= dvd7_in;
      rem6_ff <= rem6_in;
      rem7_ff <= rem7_in;
      if (cmd.commit) begin
         rom_ff  <= rom_in;
         aval_ff <= aval_in;
         irq_ff  <= level_in;
         mir_ff  <= mirror_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= mmc3bm_pkg::COUNT_RESET;
         target_ff    <= '0;
         swap_ff      <= 1'b0;
         invert_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            bank_ff[i] <= '0;
            chr_ff[i]  <= '0;
         end
         prg_ff[0]    <= '0;
         prg_ff[1]    <= PW'(1);
         prg_ff[2]    <= PW'(mmc3bm_pkg::COUNT_RESET - 7'd2);
         prg_ff[3]    <= PW'(mmc3bm_pkg::COUNT_RESET - 7'd1);
         latch_ff     <= '0;
         irqcnt_ff    <= '0;
         reload_ff    <= 1'b0;
         enabled_ff   <= 1'b0;
         level_ff     <= 1'b0;
         mirror_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         target_ff    <= target_in;
         swap_ff      <= swap_in;
         invert_ff    <= invert_in;
         bank_ff      <= bank_in;
         chr_ff       <= chr_in;
         prg_ff       <= prg_in;
         latch_ff     <= latch_in;
         irqcnt_ff    <= irqcnt_in;
         reload_ff    <= reload_in;
         enabled_ff   <= enabled_in;
         level_ff     <= level_in;
         mirror_ff    <= mirror_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_rom_address       = rom_ff;
   assign rsp_address_valid     = aval_ff;
   assign rsp_irq_line          = irq_ff;
   assign rsp_mirror_horizontal = mir_ff;

endmodule

[src/mmc3_bank_mapper_scanline_irq_core.sv]
// MMC3-style bank mapper with scanline IRQ counter, top level.
// A result is registered after its item passes the decode and commit states; a bank write
// to R6 or R7 also runs the six-step serial remainder by the bank count in between.
// Items are taken one at a time; each commit waits until the output register is free.
// Reset (synchronous): registers return to power-up values, bank count 32, no
// output pending. Uses mmc3bm_pkg, mmc3bm_req_if, mmc3bm_rsp_if, mmc3bm_ctrl, mmc3bm_dp.
module mmc3_bank_mapper_scanline_irq_core #(
   parameter logic [mmc3bm_pkg::LINE_W-1:0] VISIBLE_LINES = mmc3bm_pkg::VISIBLE_LINES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [6:0]  csr_write_data,
   mmc3bm_req_if.sink   req_ch,
   mmc3bm_rsp_if.source rsp_ch
);

   mmc3bm_pkg::ctrl_cmd_type  cmd;
   mmc3bm_pkg::dp_status_type status;

   mmc3bm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mmc3bm_dp #(
      .VISIBLE_LINES (VISIBLE_LINES)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_action            (req_ch.action),
      .req_address           (req_ch.address),
      .req_write_data        (req_ch.write_data),
      .req_scanline_number   (req_ch.scanline_number),
      .cmd                   (cmd),
      .status                (status),
      .rsp_valid             (rsp_ch.valid),
      .rsp_ready             (rsp_ch.ready),
      .rsp_rom_address       (rsp_ch.rom_address),
      .rsp_address_valid     (rsp_ch.address_valid),
      .rsp_irq_line          (rsp_ch.irq_line),
      .rsp_mirror_horizontal (rsp_ch.mirror_horizontal)
   );

endmodule

[src/mmc3bm_checker.sv]
// Port-level checks for the bank mapper core, bound to the top level.
// Depends on mmc3_bank_mapper_scanline_irq_core.
module mmc3bm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [18:0] rom_address,
   input logic        address_valid
);

   // Nothing is pending in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // An accepted item occupies the core, so the next cycle cannot accept.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted in back-to-back cycles");

   // Items that produce no ROM address report address zero.
   a_zero_address: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !address_valid) |-> (rom_address == 19'd0))
      else $error("nonzero rom address without address_valid");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before it was taken");

endmodule

bind mmc3_bank_mapper_scanline_irq_core mmc3bm_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rom_address   (rsp_ch.rom_address),
   .address_valid (rsp_ch.address_valid)
);

[tb/sv/mmc3_bank_mapper_scanline_irq_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the MMC3-style bank mapper core: a queue-fed driver,
// a response monitor with its own mapper predictor, and bank count changes between phases.
// Depends on mmc3bm_pkg, mmc3bm_req_if, mmc3bm_rsp_if and the core itself.
module mmc3_bank_mapper_scanline_irq_core_tb;

   typedef struct {
      mmc3bm_pkg::action_type act;
      logic [15:0]            addr;
      logic [7:0]             data;
      logic [8:0]             line;
   } bus_action_type;

   typedef struct {
      logic [18:0] rom;
      logic        hit;
      logic        irq;
      logic        mirror;
      int unsigned stamp;
   } mapped_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable;
   logic [6:0] csr_write_data;

   mmc3bm_req_if req_bus ();
   mmc3bm_rsp_if rsp_bus ();

   mmc3_bank_mapper_scanline_irq_core DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   bus_action_type pending_actions[$];
   mapped_type     due_results[$];
   bus_action_type offer;
   int unsigned cyc = 0;
   int          taken = 0;
   int          errors = 0;
   int          tx_gap = 0;
   int          rx_gap = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   logic        steady = 1'b0;

   // Predictor state: a private copy of everything the mapper keeps.
   logic [6:0] count_reg;
   logic [2:0] sel_reg;
   logic       prg_swap;
   logic       chr_flip;
   logic [7:0] bank_r [8];
   logic [7:0] chr_page [8];
   logic [5:0] prg_page [4];
   logic [7:0] irq_reload_val;
   logic [7:0] irq_count;
   logic       irq_reload_req;
   logic       irq_armed;
   logic       irq_out;
   logic       mirror_h;

   function automatic int unsigned bank_total();
      int unsigned n;
      n = 32'(count_reg);
      if (n < 2) n = 2;
      if (n > 64) n = 64;
      return n;
   endfunction

   function automatic void load_default_pages();
      int unsigned n;
      n = bank_total();
      prg_page[0] = 6'd0;
      prg_page[1] = 6'd1;
      prg_page[2] = 6'(n - 2);
      prg_page[3] = 6'(n - 1);
   endfunction

   function automatic void rebuild_prg();
      int unsigned n;
      logic [5:0]  sel;
      n = bank_total();
      sel = 6'(int'(bank_r[6][5:0]) % n);
      if (prg_swap) begin
         prg_page[2] = sel;
         prg_page[0] = 6'(n - 2);
      end else begin
         prg_page[0] = sel;
         prg_page[2] = 6'(n - 2);
      end
      prg_page[1] = 6'(int'(bank_r[7][5:0]) % n);
      prg_page[3] = 6'(n - 1);
   endfunction

   function automatic void rebuild_chr();
      int lo;
      int hi;
      lo = chr_flip ? 4 : 0;
      hi = chr_flip ? 0 : 4;
      chr_page[lo]     = bank_r[0] & 8'hFE;
      chr_page[lo + 1] = bank_r[0] | 8'h01;
      chr_page[lo + 2] = bank_r[1] & 8'hFE;
      chr_page[lo + 3] = bank_r[1] | 8'h01;
      for (int i = 0; i < 4; i++) chr_page[hi + i] = bank_r[2 + i];
   endfunction

   function automatic void reset_model();
      count_reg = mmc3bm_pkg::COUNT_RESET;
      sel_reg = '0;
      prg_swap = 1'b0;
      chr_flip = 1'b0;
      for (int i = 0; i < 8; i++) begin
         bank_r[i] = '0;
         chr_page[i] = '0;
      end
      load_default_pages();
      irq_reload_val = '0;
      irq_count = '0;
      irq_reload_req = 1'b0;
      irq_armed = 1'b0;
      irq_out = 1'b0;
      mirror_h = 1'b0;
   endfunction

   function automatic void apply_cpu_write(logic [15:0] addr, logic [7:0] data);
      case ({addr[15:13], addr[0]})
         mmc3bm_pkg::REG_SELECT: begin
            sel_reg = data[2:0];
            prg_swap = data[6];
            chr_flip = data[7];
         end
         mmc3bm_pkg::REG_BANK_DATA: begin
            if (sel_reg < 3'd6) begin
               bank_r[sel_reg] = data;
               rebuild_chr();
            end else begin
               bank_r[sel_reg] = {2'b00, data[5:0]};
               rebuild_prg();
            end
         end
         mmc3bm_pkg::REG_MIRROR: mirror_h = data[0];
         mmc3bm_pkg::REG_IRQ_LATCH: irq_reload_val = data;
         mmc3bm_pkg::REG_IRQ_RELOAD: begin
            irq_reload_req = 1'b1;
            irq_count = '0;
         end
         mmc3bm_pkg::REG_IRQ_DISABLE: begin
            irq_armed = 1'b0;
            irq_out = 1'b0;
         end
         mmc3bm_pkg::REG_IRQ_ENABLE: irq_armed = 1'b1;
         default: ;
      endcase
   endfunction

   function automatic void count_scanline(logic [8:0] line);
      if (line < mmc3bm_pkg::VISIBLE_LINES) begin
         if (irq_reload_req) begin
            irq_count = irq_reload_val;
            irq_reload_req = 1'b0;
         end else if (irq_count != 0) begin
            irq_count = irq_count - 8'd1;
         end
         if (irq_count == 0) begin
            irq_reload_req = 1'b1;
            if (irq_armed) irq_out = 1'b1;
         end
      end
   endfunction

   function automatic mapped_type map_access(bus_action_type a);
      mapped_type r;
      r.rom = '0;
      r.hit = 1'b0;
      r.stamp = 0;
      case (a.act)
         mmc3bm_pkg::ACT_REG_WRITE: apply_cpu_write(a.addr, a.data);
         mmc3bm_pkg::ACT_PRG_READ: begin
            if (a.addr >= 16'h8000) begin
               r.rom = {prg_page[a.addr[14:13]], a.addr[12:0]};
               r.hit = 1'b1;
            end
         end
         mmc3bm_pkg::ACT_CHR_READ: begin
            r.rom = {1'b0, chr_page[a.addr[12:10]], a.addr[9:0]};
            r.hit = 1'b1;
         end
         default: count_scanline(a.line);
      endcase
      r.irq = irq_out;
      r.mirror = mirror_h;
      return r;
   endfunction

   // Mostly back-to-back, some short pauses, a few long ones.
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] reg_addr(mmc3bm_pkg::reg_code_type c, logic scatter);
      logic [11:0] mid;
      mid = scatter ? 12'($urandom) : 12'h000;
      return {c[3:1], mid, c[0]};
   endfunction

   function automatic logic [8:0] pick_line();
      if ($urandom_range(0, 99) < 85) return 9'($urandom_range(0, 239));
      return 9'($urandom_range(240, 511));
   endfunction

   // Fields that the action does not use get random values.
   task automatic add(mmc3bm_pkg::action_type act, logic [15:0] addr, logic [7:0] data,
                      logic [8:0] line);
      bus_action_type a;
      a.act = act;
      a.addr = (act == mmc3bm_pkg::ACT_SCANLINE) ? 16'($urandom) : addr;
      a.data = (act == mmc3bm_pkg::ACT_REG_WRITE) ? data : 8'($urandom);
      a.line = (act == mmc3bm_pkg::ACT_SCANLINE) ? line : 9'($urandom);
      pending_actions.push_back(a);
   endtask

   task automatic queue_directed();
      add(mmc3bm_pkg::ACT_PRG_READ, 16'h0000, '0, '0);
      add(mmc3bm_pkg::ACT_PRG_READ, 16'h7FFF, '0, '0);
      add(mmc3bm_pkg::ACT_PRG_READ, 16'h8000, '0, '0);
      add(mmc3bm_pkg::ACT_PRG_READ, 16'hFFFF, '0, '0);
      add(mmc3bm_pkg::ACT_CHR_READ, 16'h0000, '0, '0);
      add(mmc3bm_pkg::ACT_CHR_READ, 16'h1FFF, '0, '0);
      add(mmc3bm_pkg::ACT_CHR_READ, 16'hFFFF, '0, '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_SELECT, 1'b0), 8'hC7, '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_BANK_DATA, 1'b0), 8'hFF, '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_SELECT, 1'b0), 8'h46, '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_BANK_DATA, 1'b0), 8'h3F, '0);
      add(mmc3bm_pkg::ACT_PRG_READ, 16'h8000, '0, '0);
      add(mmc3bm_pkg::ACT_PRG_READ, 16'hC000, '0, '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_SELECT, 1'b0), 8'h80, '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_BANK_DATA, 1'b0), 8'hFF, '0);
      add(mmc3bm_pkg::ACT_CHR_READ, 16'h1000, '0, '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_MIRROR, 1'b0), 8'h01, '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_RAM_PROTECT, 1'b0), 8'hFF,
          '0);
      // A zero latch keeps the counter at zero, so every visible line fires.
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_IRQ_LATCH, 1'b0), 8'h00, '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_IRQ_RELOAD, 1'b0),
          8'($urandom), '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_IRQ_ENABLE, 1'b0),
          8'($urandom), '0);
      add(mmc3bm_pkg::ACT_SCANLINE, '0, '0, 9'd0);
      add(mmc3bm_pkg::ACT_SCANLINE, '0, '0, 9'd239);
      add(mmc3bm_pkg::ACT_SCANLINE, '0, '0, 9'd240);
      add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_IRQ_DISABLE, 1'b0),
          8'($urandom), '0);
      add(mmc3bm_pkg::ACT_REG_WRITE, 16'h6000, 8'hFF, '0);
   endtask

   task automatic queue_random(int n);
      int base;
      int pick;
      base = pending_actions.size();
      while (pending_actions.size() - base < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_SELECT, 1'b1),
                8'($urandom), '0);
            add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_BANK_DATA, 1'b1),
                8'($urandom), '0);
         end else if (pick < 32) begin
            add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_IRQ_LATCH, 1'b1),
                ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)), '0);
            if ($urandom_range(0, 3) != 0)
               add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_IRQ_RELOAD, 1'b1),
                   8'($urandom), '0);
            add(mmc3bm_pkg::ACT_REG_WRITE,
                reg_addr(($urandom_range(0, 4) == 0) ? mmc3bm_pkg::REG_IRQ_DISABLE
                         : mmc3bm_pkg::REG_IRQ_ENABLE, 1'b1),
                8'($urandom), '0);
            repeat ($urandom_range(1, 12)) add(mmc3bm_pkg::ACT_SCANLINE, '0, '0, pick_line());
         end else if (pick < 47) begin
            add(mmc3bm_pkg::ACT_PRG_READ, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                : 16'($urandom_range(16'h8000, 16'hFFFF)), '0, '0);
         end else if (pick < 60) begin
            add(mmc3bm_pkg::ACT_CHR_READ, 16'($urandom), '0, '0);
         end else if (pick < 72) begin
            repeat ($urandom_range(1, 6)) add(mmc3bm_pkg::ACT_SCANLINE, '0, '0, pick_line());
         end else if (pick < 80) begin
            add(mmc3bm_pkg::ACT_REG_WRITE,
                reg_addr(($urandom_range(0, 3) == 0) ? mmc3bm_pkg::REG_RAM_PROTECT
                         : mmc3bm_pkg::REG_MIRROR, 1'b1),
                8'($urandom), '0);
         end else if (pick < 86) begin
            add(mmc3bm_pkg::ACT_REG_WRITE, reg_addr(mmc3bm_pkg::REG_IRQ_DISABLE, 1'b1),
                8'($urandom), '0);
         end else begin
            add(mmc3bm_pkg::action_type'($urandom_range(0, 3)), 16'($urandom),
                8'($urandom), 9'($urandom));
         end
      end
   endtask

   task automatic drain();
      while (pending_actions.size() != 0 || req_bus.valid || due_results.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic set_bank_count(logic [6:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      count_reg = value;
      load_default_pages();
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) cyc <= cyc + 1;

   // Driver: presents queued items and predicts each one as it is accepted.
   always @(posedge clock) begin : drive_proc
      logic       next_valid;
      mapped_type r;
      next_valid = req_bus.valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            r = map_access(offer);
            r.stamp = cyc;
            due_results.push_back(r);
            taken <= taken + 1;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (tx_gap != 0) begin
               tx_gap--;
            end else if (pending_actions.size() != 0) begin
               offer = pending_actions.pop_front();
               req_bus.action <= offer.act;
               req_bus.address <= offer.addr;
               req_bus.write_data <= offer.data;
               req_bus.scanline_number <= offer.line;
               next_valid = 1'b1;
               tx_gap = pick_gap();
            end
         end
      end
      req_bus.valid <= next_valid;
   end

   // Once, the receiver stops for a long stretch so the core backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && taken >= 150) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end
   end

   // Monitor: an expectation stamped with this same edge cannot be answered yet.
   always @(posedge clock) begin : check_proc
      mapped_type want;
      logic       fire;
      fire = rsp_bus.valid && rsp_bus.ready && !reset;
      if (fire) begin
         if (due_results.size() == 0 || due_results[0].stamp == cyc) begin
            $error("result item with no item outstanding");
            errors++;
         end else begin
            want = due_results.pop_front();
            if (rsp_bus.rom_address !== want.rom) begin
               $error("rom_address: expected %h, actual %h", want.rom, rsp_bus.rom_address);
               errors++;
            end
            if (rsp_bus.address_valid !== want.hit) begin
               $error("address_valid: expected %b, actual %b", want.hit,
                      rsp_bus.address_valid);
               errors++;
            end
            if (rsp_bus.irq_line !== want.irq) begin
               $error("irq_line: expected %b, actual %b", want.irq, rsp_bus.irq_line);
               errors++;
            end
            if (rsp_bus.mirror_horizontal !== want.mirror) begin
               $error("mirror_horizontal: expected %b, actual %b", want.mirror,
                      rsp_bus.mirror_horizontal);
               errors++;
            end
         end
      end
      if (fire) rx_gap = pick_gap();
      else if (rx_gap != 0) rx_gap--;
      rsp_bus.ready <= (rx_gap == 0) && (hold_left == 0);
   end

   initial begin
      #5_000_000;
      $display("mmc3_bank_mapper_scanline_irq_core_tb: errors");
      $finish;
   end

   initial begin
      logic [6:0] counts [8];
      counts = '{mmc3bm_pkg::COUNT_RESET, 7'd64, 7'd2, 7'd127, 7'd0, 7'd1, 7'd65,
                 7'($urandom)};
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      reset_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // The first phase runs on the count that reset leaves behind.
      for (int p = 0; p < 8; p++) begin
         if (p != 0) set_bank_count(counts[p]);
         steady = (p == 3);
         queue_directed();
         queue_random(50);
         drain();
      end
      repeat (20) @(negedge clock);
      if (errors == 0 && due_results.size() == 0)
         $display("mmc3_bank_mapper_scanline_irq_core_tb: clean");
      else
         $display("mmc3_bank_mapper_scanline_irq_core_tb: errors");
      $finish;
   end

endmodule

[sim.f]
src/mmc3bm_pkg.sv
src/mmc3bm_req_if.sv
src/mmc3bm_rsp_if.sv
src/mmc3bm_ctrl.sv
src/mmc3bm_dp.sv
src/mmc3_bank_mapper_scanline_irq_core.sv
src/mmc3bm_checker.sv
tb/sv/mmc3_bank_mapper_scanline_irq_core_tb.sv
